FILE: hdl/sha_pkg.sv
package sha_pkg;

    typedef logic [31:0] t_word;

    localparam t_word HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        t_word      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } t_out_item;

    function automatic t_word ror32(t_word v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: hdl/sha_if.sv
interface sha_in_if import sha_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sha_out_if import sha_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/sha256_message_hasher.sv
// SHA-256 over a byte stream. One transaction carries an optional byte and
// an end-of-message flag. A byte that does not complete a 64-byte block is
// taken without a stall; the byte that completes one starts a run of the
// single round unit over all rounds (schedule words are made on the fly in
// a 16-word sliding window) and then a fold into the chaining hash, and no
// input is taken until the fold is done. An end flag adds padding at one
// byte per cycle (paused while a full block compresses), one or two
// compressions, and then eight digest transactions, h0 first; the block takes
// no input until the last of them is taken.
module sha256_message_hasher import sha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [5:0]  r_rnd, n_rnd;
    logic [63:0] r_len, n_len;
    logic        r_end, n_end;
    logic        r_len_done, n_len_done;
    logic [2:0]  r_oidx, n_oidx;
    t_word       r_h [8], n_h [8];
    t_word       r_v [8], n_v [8];
    t_word       r_w [16], n_w [16];

    logic  push_en;
    logic [7:0] push_b;
    t_word s0, s1, w_new, wt, t1, t2;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.data.digest_word = r_h[r_oidx];
    assign o_out.data.word_index  = r_oidx;
    assign o_out.data.last_word   = (r_oidx == 3'd7);

    // schedule word and round unit
    always_comb begin
        s0 = ror32(r_w[1], 7) ^ ror32(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror32(r_w[14], 17) ^ ror32(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        wt = (r_rnd < 6'd16) ? r_w[r_rnd[3:0]] : w_new;
        t1 = r_v[7] + (ror32(r_v[4], 6) ^ ror32(r_v[4], 11) ^ ror32(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_rnd] + wt;
        t2 = (ror32(r_v[0], 2) ^ ror32(r_v[0], 13) ^ ror32(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_fill = r_fill; n_rnd = r_rnd; n_len = r_len;
        n_end = r_end; n_len_done = r_len_done; n_oidx = r_oidx;
        n_h = r_h; n_v = r_v; n_w = r_w;
        push_en = 1'b0; push_b = 8'h00;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_end = i_in.data.end_of_message;
                    if (i_in.data.byte_present) begin
                        push_en = 1'b1;
                        push_b  = i_in.data.msg_byte;
                        n_len   = r_len + 64'd8;
                    end
                    if (i_in.data.end_of_message)
                        n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                push_b  = r_len_done ? 8'h00 : 8'h80;
                n_len_done = 1'b1;
                if (r_len_done && r_fill == 6'd56) begin
                    push_en = 1'b0;
                    n_w[14] = r_len[63:32];
                    n_w[15] = r_len[31:0];
                    n_fill  = 6'd0;
                    n_v = r_h; n_rnd = 6'd0;
                    n_end = 1'b0;
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                n_v[7] = r_v[6]; n_v[6] = r_v[5]; n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2]; n_v[2] = r_v[1]; n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                if (r_rnd >= 6'd16) begin
                    for (int i = 0; i < 15; i++) n_w[i] = r_w[i + 1];
                    n_w[15] = w_new;
                end
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) n_h[i] = r_h[i] + r_v[i];
                n_oidx = 3'd0;
                n_state = r_end ? ST_PAD : (r_len_done ? ST_OUT : ST_IDLE);
                if (!r_end && r_len_done) n_len_done = 1'b0;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_h = HASH_INIT; n_len = '0; n_fill = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // byte packing into the block buffer
        if (push_en) begin
            if (r_fill[1:0] == 2'd0) n_w[r_fill[5:2]] = {push_b, 24'h0};
            else n_w[r_fill[5:2]][(3 - r_fill[1:0]) * 8 +: 8] = push_b;
            n_fill = r_fill + 6'd1;
            if (r_fill == 6'd63) begin
                n_v = r_h; n_rnd = 6'd0; n_state = ST_RND;
                if (r_state == ST_IDLE && !i_in.data.end_of_message) n_end = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v; r_w <= n_w; r_rnd <= n_rnd; r_oidx <= n_oidx;
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_fill <= '0; r_len <= '0; r_end <= 1'b0;
            r_len_done <= 1'b0; r_h <= HASH_INIT;
        end else begin
            r_state <= n_state; r_fill <= n_fill; r_len <= n_len; r_end <= n_end;
            r_len_done <= n_len_done; r_h <= n_h;
        end
    end

endmodule

FILE: verif/sha256_message_hasher_test.sv
`timescale 1ns / 100ps

module sha256_message_hasher_test;
    import sha_pkg::*;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_message_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // model state of the hasher
    t_word   hash_state [8];
    t_word   msg_block  [16];
    logic [63:0] msg_bits;
    int      fill_pos;

    t_in_item  pending_items [$];
    t_out_item digest_queue  [$];
    int  fail_count;
    int  cycle_count;
    int  hold_off_left;

    function automatic t_word rotr(t_word v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // one compression into hash_state
    task automatic compress_model();
        t_word w [64];
        t_word v [8];
        t_word s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic absorb_byte(logic [7:0] b);
        int wi;
        int lane;
        wi = fill_pos >> 2;
        lane = fill_pos & 3;
        if (lane == 0) msg_block[wi] = 32'(b) << ((3 - lane) * 8);
        else msg_block[wi] |= 32'(b) << ((3 - lane) * 8);
        fill_pos++;
        if (fill_pos == 64) begin
            compress_model();
            fill_pos = 0;
        end
    endtask

    // predict digests for one accepted transaction
    task automatic predict_digest(t_in_item it);
        t_out_item o;
        if (it.byte_present) begin
            absorb_byte(it.msg_byte);
            msg_bits += 64'd8;
        end
        if (it.end_of_message) begin
            absorb_byte(8'h80);
            while (fill_pos != 56) absorb_byte(8'h00);
            msg_block[14] = msg_bits[63:32];
            msg_block[15] = msg_bits[31:0];
            compress_model();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_state[i];
                o.word_index = 3'(i);
                o.last_word = (i == 7);
                digest_queue.push_back(o);
            end
            hash_state = HASH_INIT;
            msg_bits = '0;
            fill_pos = 0;
        end
    endtask

    function automatic t_in_item make_item(logic [7:0] b, bit p, bit e);
        t_in_item it;
        it.msg_byte = b;
        it.byte_present = p;
        it.end_of_message = e;
        return it;
    endfunction

    // stimulus
    initial begin
        int len;
        hash_state = HASH_INIT;
        msg_bits = '0;
        fill_pos = 0;
        fail_count = 0;
        // directed: empty message, idle items, extremes, byte with end mark
        pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
        pending_items.push_back(make_item(8'hff, 1'b0, 1'b0));
        pending_items.push_back(make_item(8'h61, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h62, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'h63, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'h00, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'hff, 1'b1, 1'b0));
        pending_items.push_back(make_item(8'haa, 1'b0, 1'b0));
        pending_items.push_back(make_item(8'h55, 1'b1, 1'b1));
        pending_items.push_back(make_item(8'hff, 1'b1, 1'b1));
        // random messages, lengths around block and padding boundaries
        while (pending_items.size() < 400) begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(54, 58);
                2: len = $urandom_range(60, 70);
                default: len = $urandom_range(110, 130);
            endcase
            // keep the total near the planned item count
            if (len > 405 - int'(pending_items.size()))
                len = 405 - int'(pending_items.size());
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b0));
                pending_items.push_back(make_item(8'($urandom), 1'b1,
                    (i == len - 1) && $urandom_range(0, 1)));
            end
            if (len == 0 || !pending_items[$].end_of_message)
                pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b1));
        end
    end

    // reset and cycle limit
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAIL");
            $finish;
        end
    end
    initial cycle_count = 0;

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        burst_left = 0;
        gap_left = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_digest(in_ch.data);
                void'(pending_items.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the current transaction
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0
                         && !(in_ch.valid && in_ch.ready && pending_items.size() == 0)) begin
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_items[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern with one long hold-off
    bit long_done;
    initial begin
        out_ch.ready = 1'b0;
        hold_off_left = 0;
        long_done = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_off_left > 0) begin
                hold_off_left <= hold_off_left - 1;
                out_ch.ready <= 1'b0;
            end else if (!long_done && cycle_count > 3000) begin
                long_done <= 1'b1;
                hold_off_left <= 600;
                out_ch.ready <= 1'b0;
            end else if ((cycle_count / 300) % 2 == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_queue.size() == 0) begin
                $display("%0t unexpected digest transaction %h", $time, out_ch.data);
                fail_count <= fail_count + 1;
            end else begin
                want = digest_queue.pop_front();
                if (out_ch.data.digest_word !== want.digest_word
                    || out_ch.data.word_index !== want.word_index
                    || out_ch.data.last_word !== want.last_word) begin
                    $display("%0t mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                        $time, want.digest_word, want.word_index, want.last_word,
                        out_ch.data.digest_word, out_ch.data.word_index,
                        out_ch.data.last_word);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // end of run
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        wait (pending_items.size() == 0 && !in_ch.valid);
        wait (digest_queue.size() == 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && digest_queue.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
